FILE: hw/rtl/bprq_pkg.sv
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared widths, codes and interface types of the priority ready queue.
// ----------------------------------------------------------------------------
package bprq_pkg;

   // request / response field widths
   localparam int FUNC_W    = 2;
   localparam int TASK_ID_W = 6;
   localparam int PRIO_W    = 8;
   localparam int STATUS_W  = 2;

   // number of distinct values the id and priority fields can carry
   localparam int TASK_SPACE = 1 << TASK_ID_W;
   localparam int PRIO_SPACE = 1 << PRIO_W;

   // level search works on 8-bit chunks of the occupancy bitmap
   localparam int CHUNK_LOG  = 3;
   localparam int CHUNK_BITS = 1 << CHUNK_LOG;

   // default configuration
   localparam int DEF_WORD_BITS    = 64;
   localparam int DEF_BITMAP_WORDS = 4;
   localparam int DEF_MAX_TASKS    = 64;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2
   } status_type;

   // bitmap update from the sequencer
   typedef struct packed {
      logic              set_bit;
      logic              clear_bit;
      logic [PRIO_W-1:0] level;
   } map_cmd_type;

   // result of the highest-level search
   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] level;
   } map_best_type;

endpackage

FILE: hw/rtl/bprq_level_map.sv
// ----------------------------------------------------------------------------
// bprq_level_map
// Level occupancy bitmap with a two-stage highest-set-level search.
// ----------------------------------------------------------------------------
module bprq_level_map
   import bprq_pkg::*;
#(
   parameter int LEVELS = PRIO_SPACE
)(
   input  logic              clock,
   input  logic              reset,
   input  map_cmd_type       cmd,
   input  logic [PRIO_W-1:0] probe_level,
   output logic              probe_busy,
   output map_best_type      best
);

   localparam int LIW   = $clog2(LEVELS);
   localparam int NCH   = (LEVELS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PAD_W = NCH * CHUNK_BITS;

   logic [LEVELS-1:0]     bitmap_ff;
   logic [PAD_W-1:0]      padded;
   logic [CHUNK_BITS-1:0] chunks [NCH];

   logic                  any_ff, any_in;
   logic [CW-1:0]         chunk_sel_ff, chunk_sel_in;
   logic [CHUNK_LOG-1:0]  bit_pos;
   logic [CHUNK_BITS-1:0] sel_chunk;
   map_best_type          best_ff, best_in;

   assign padded     = PAD_W'(bitmap_ff);
   assign probe_busy = bitmap_ff[LIW'(probe_level)];

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         chunks[c] = padded[c*CHUNK_BITS +: CHUNK_BITS];
      end
   end

   // stage 1: highest non-empty chunk
   always_comb begin
      any_in       = 1'b0;
      chunk_sel_in = '0;
      for (int c = 0; c < NCH; c++) begin
         if (|chunks[c]) begin
            any_in       = 1'b1;
            chunk_sel_in = CW'(c);
         end
      end
   end

   // stage 2: highest set bit inside that chunk
   assign sel_chunk = chunks[chunk_sel_ff];

   always_comb begin
      bit_pos = '0;
      for (int b = 0; b < CHUNK_BITS; b++) begin
         if (sel_chunk[b]) begin
            bit_pos = CHUNK_LOG'(b);
         end
      end
      best_in.valid = any_ff;
      best_in.level = PRIO_W'({chunk_sel_ff, bit_pos});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff     <= '0;
         any_ff        <= 1'b0;
         best_ff.valid <= 1'b0;
      end else begin
         if (cmd.set_bit) begin
            bitmap_ff[LIW'(cmd.level)] <= 1'b1;
         end else if (cmd.clear_bit) begin
            bitmap_ff[LIW'(cmd.level)] <= 1'b0;
         end
         any_ff        <= any_in;
         best_ff.valid <= best_in.valid;
      end
      chunk_sel_ff  <= chunk_sel_in;
      best_ff.level <= best_in.level;
   end

   assign best = best_ff;

endmodule

FILE: hw/rtl/bitmap_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue
// Scheduler ready queue: one linked FIFO per priority level, best level
// found from an occupancy bitmap.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------
//  request   req_func, req_task_id, req_priority_req  start high, busy low
//  response  rsp_status, rsp_best_valid,              rsp_strobe, one cycle,
//            rsp_best_task, rsp_best_priority         no backpressure
//
//  Between acceptances a request passes S_CHECK, S_UPDATE, S_FIND1, S_FIND2
//  and S_HEAD, plus S_FOLD once per wrap of a priority at or above the level
//  count (priority minus level count, repeated). This order is set by the
//  single-port link and head/tail memories (read in S_CHECK, written in
//  S_UPDATE), the two-stage bitmap search, and the winning level's head read.
//  rsp_strobe rises in the cycle after the head read; busy is low in that
//  cycle, so the next request may already be taken there.
//  Reset (synchronous) empties all levels; the memories need no clearing.
//  The response side cannot stall the block.
//
module bitmap_priority_ready_queue
   import bprq_pkg::*;
#(
   parameter int WORD_BITS    = DEF_WORD_BITS,
   parameter int BITMAP_WORDS = DEF_BITMAP_WORDS,
   parameter int MAX_TASKS    = DEF_MAX_TASKS
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [PRIO_W-1:0]    req_priority_req,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_best_valid,
   output logic [TASK_ID_W-1:0] rsp_best_task,
   output logic [PRIO_W-1:0]    rsp_best_priority
);

   // Only levels below the priority field's range can ever be occupied,
   // and only task ids the id field can carry can ever be queued.
   localparam int NUM_LEVELS = WORD_BITS * BITMAP_WORDS;
   localparam int LEVELS     = (NUM_LEVELS < PRIO_SPACE) ? NUM_LEVELS : PRIO_SPACE;
   localparam int LIW        = $clog2(LEVELS);
   localparam int SLOTS      = (MAX_TASKS < TASK_SPACE) ? MAX_TASKS : TASK_SPACE;
   localparam int TW         = $clog2(SLOTS);

   localparam logic [PRIO_W:0]    LEVELS_CMP = (PRIO_W+1)'(LEVELS);
   localparam logic [PRIO_W-1:0]  FOLD_STEP  = PRIO_W'(LEVELS);
   localparam logic [TASK_ID_W:0] SLOTS_CMP  = (TASK_ID_W+1)'(SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FOLD,    // wrap priority into the level range
      S_CHECK,   // read links, head, tail, task level
      S_UPDATE,  // write links, head, tail, bitmap
      S_FIND1,   // bitmap search, chunk stage
      S_FIND2,   // bitmap search, bit stage
      S_HEAD     // read head of the best level
   } state_type;

   state_type              state_ff, state_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [TASK_ID_W-1:0]   task_ff, task_in;
   logic [PRIO_W-1:0]      lvl_ff, lvl_in;
   status_type             status_ff, status_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_best_valid_ff, rsp_best_valid_in;
   logic [PRIO_W-1:0]      rsp_best_priority_ff, rsp_best_priority_in;

   // memories
   logic [TW-1:0]          head_mem [LEVELS];
   logic [TW-1:0]          tail_mem [LEVELS];
   logic [TW-1:0]          next_mem [SLOTS];
   logic [TW-1:0]          prev_mem [SLOTS];
   logic [LIW-1:0]         task_level_mem [SLOTS];
   logic [SLOTS-1:0]       queued_ff;

   logic [TW-1:0]          head_rd_ff, tail_rd_ff, next_rd_ff, prev_rd_ff;
   logic [LIW-1:0]         task_level_rd_ff;

   logic [LIW-1:0]         lvl_idx, best_idx, head_addr;
   logic [TW-1:0]          task_idx, next_addr, prev_addr;
   logic [PRIO_W-1:0]      lvl_fold;
   logic                   task_ok, queued_hit, lvl_busy;
   logic                   add_go, rem_go, is_head, is_tail;

   logic                   head_we, tail_we, next_we, prev_we, task_level_we;
   logic                   queued_set, queued_clr;
   logic [TW-1:0]          head_wdata, tail_wdata, next_wdata, prev_wdata;
   logic [TW-1:0]          next_waddr, prev_waddr;

   map_cmd_type            map_cmd;
   map_best_type           map_best;

   bprq_level_map #(
      .LEVELS (LEVELS)
   ) u_level_map (
      .clock       (clock),
      .reset       (reset),
      .cmd         (map_cmd),
      .probe_level (lvl_ff),
      .probe_busy  (lvl_busy),
      .best        (map_best)
   );

   assign lvl_idx    = LIW'(lvl_ff);
   assign task_idx   = TW'(task_ff);
   assign best_idx   = LIW'(map_best.level);
   assign lvl_fold   = lvl_ff - FOLD_STEP;
   assign task_ok    = ({1'b0, task_ff} < SLOTS_CMP);
   assign queued_hit = task_ok && queued_ff[task_idx];

   // removal bookkeeping uses data read in S_CHECK
   assign is_head = (head_rd_ff == task_idx);
   assign is_tail = (tail_rd_ff == task_idx);
   assign add_go  = (state_ff == S_UPDATE) && (func_ff == FN_ADD) && (status_ff == ST_OK);
   assign rem_go  = (state_ff == S_UPDATE) && (func_ff == FN_REMOVE) &&
                    (status_ff == ST_OK) && (task_level_rd_ff == lvl_idx);

   // list updates
   always_comb begin
      head_we       = 1'b0;
      tail_we       = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      task_level_we = 1'b0;
      queued_set    = 1'b0;
      queued_clr    = 1'b0;
      head_wdata    = task_idx;
      tail_wdata    = task_idx;
      next_wdata    = task_idx;
      prev_wdata    = tail_rd_ff;
      next_waddr    = tail_rd_ff;
      prev_waddr    = task_idx;
      map_cmd.set_bit   = 1'b0;
      map_cmd.clear_bit = 1'b0;
      map_cmd.level     = lvl_ff;

      if (add_go) begin
         // append at tail; an empty level gets a new head and its bit
         tail_we       = 1'b1;
         task_level_we = 1'b1;
         queued_set    = 1'b1;
         if (lvl_busy) begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end else begin
            head_we         = 1'b1;
            map_cmd.set_bit = 1'b1;
         end
      end else if (rem_go) begin
         queued_clr = 1'b1;
         priority if (is_head && is_tail) begin
            map_cmd.clear_bit = 1'b1;
         end else if (is_head) begin
            head_we    = 1'b1;
            head_wdata = next_rd_ff;
         end else if (is_tail) begin
            tail_we    = 1'b1;
            tail_wdata = prev_rd_ff;
         end else begin
            // unlink from the middle
            next_we    = 1'b1;
            next_waddr = prev_rd_ff;
            next_wdata = next_rd_ff;
            prev_we    = 1'b1;
            prev_waddr = next_rd_ff;
            prev_wdata = prev_rd_ff;
         end
      end
   end

   assign head_addr = (state_ff == S_HEAD) ? best_idx : lvl_idx;
   assign next_addr = (state_ff == S_UPDATE) ? next_waddr : task_idx;
   assign prev_addr = (state_ff == S_UPDATE) ? prev_waddr : task_idx;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_addr] <= head_wdata;
      end else if (state_ff == S_CHECK || state_ff == S_HEAD) begin
         head_rd_ff <= head_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[lvl_idx] <= tail_wdata;
      end else if (state_ff == S_CHECK) begin
         tail_rd_ff <= tail_mem[lvl_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_addr] <= next_wdata;
      end else if (state_ff == S_CHECK) begin
         next_rd_ff <= next_mem[next_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_addr] <= prev_wdata;
      end else if (state_ff == S_CHECK) begin
         prev_rd_ff <= prev_mem[prev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (task_level_we) begin
         task_level_mem[task_idx] <= lvl_idx;
      end else if (state_ff == S_CHECK) begin
         task_level_rd_ff <= task_level_mem[task_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
      end else if (queued_set) begin
         queued_ff[task_idx] <= 1'b1;
      end else if (queued_clr) begin
         queued_ff[task_idx] <= 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in             = state_ff;
      func_in              = func_ff;
      task_in              = task_ff;
      lvl_in               = lvl_ff;
      status_in            = status_ff;
      rsp_strobe_in        = 1'b0;
      rsp_status_in        = rsp_status_ff;
      rsp_best_valid_in    = rsp_best_valid_ff;
      rsp_best_priority_in = rsp_best_priority_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = req_func;
               task_in   = req_task_id;
               lvl_in    = req_priority_req;
               status_in = ST_OK;
               state_in  = ({1'b0, req_priority_req} < LEVELS_CMP) ? S_CHECK : S_FOLD;
            end
         end
         S_FOLD: begin
            lvl_in = lvl_fold;
            if ({1'b0, lvl_fold} < LEVELS_CMP) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (func_ff)
               FN_ADD:    status_in = (!task_ok || queued_hit) ? ST_DUPLICATE : ST_OK;
               FN_REMOVE: status_in = queued_hit ? ST_OK : ST_NOT_FOUND;
               default:   status_in = ST_OK;
            endcase
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // queued, but at another level
            if (func_ff == FN_REMOVE && status_ff == ST_OK && !rem_go) begin
               status_in = ST_NOT_FOUND;
            end
            state_in = S_FIND1;
         end
         S_FIND1: begin
            state_in = S_FIND2;
         end
         S_FIND2: begin
            state_in = S_HEAD;
         end
         S_HEAD: begin
            rsp_strobe_in        = 1'b1;
            rsp_status_in        = status_ff;
            rsp_best_valid_in    = map_best.valid;
            rsp_best_priority_in = map_best.valid ? map_best.level : '0;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      func_ff              <= func_in;
      task_ff              <= task_in;
      lvl_ff               <= lvl_in;
      status_ff            <= status_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_best_valid_ff    <= rsp_best_valid_in;
      rsp_best_priority_ff <= rsp_best_priority_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_best_valid    = rsp_best_valid_ff;
   assign rsp_best_priority = rsp_best_priority_ff;
   // head read of S_HEAD is held in head_rd_ff during the strobe cycle
   assign rsp_best_task     = rsp_best_valid_ff ? TASK_ID_W'(head_rd_ff) : '0;

endmodule
